// ===== sv/uart_pkg.sv =====
// Shared types and constants for the UART transceiver.
`timescale 1ns / 1ps

package uart_pkg;

  localparam int unsigned CNT_W  = 16;
  localparam int unsigned BYTE_W = 8;

  localparam logic [CNT_W-1:0] BIT_TICKS_RST = 16'd8;

  // Frame phase, shared by receiver and transmitter.
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_FIRST  = 4'b0010,
    PH_SECOND = 4'b0100,
    PH_LAST   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } rx_res_t;

  typedef struct packed {
    logic line;
    logic busy;
  } tx_res_t;

endpackage

// ===== sv/uart_8n1_transceiver_unit.sv =====
// Top level of the UART transceiver: config register, rx/tx cores, result register.
// Each request is one tick of the bit-timing clock and yields exactly one result:
// the transmit level and busy flag after that tick, plus a received byte with
// its valid flag (byte reads zero when no byte is reported). The block takes one
// request per cycle while in_ready_o is high; the receiver and transmitter state
// advance in the cycle of acceptance and the result lands in a single output
// register in the cycle after. in_ready_o drops only while that register holds a
// result that the consumer has not taken. bit_ticks (reset 8) sets the bit
// period in ticks; the receiver waits bit_ticks/2 + bit_ticks ticks after the
// start edge before its first sample. Write bit_ticks only while idle; a new
// value takes effect the next time a bit counter loads. The stop bit is not checked.
`timescale 1ns / 1ps

module uart_8n1_transceiver_unit #(
  parameter int unsigned DATA_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [uart_pkg::CNT_W-1:0]  cfg_wdata_i,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        rx_line_i,
  input  logic                        send_valid_i,
  input  logic [uart_pkg::BYTE_W-1:0] send_byte_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        tx_line_o,
  output logic                        tx_busy_o,
  output logic                        rx_valid_o,
  output logic [uart_pkg::BYTE_W-1:0] rx_byte_o
);

  logic [uart_pkg::CNT_W-1:0] bit_ticks_q;
  logic                       adv;
  uart_pkg::rx_res_t          rx_res;
  uart_pkg::tx_res_t          tx_res;
  logic                       out_valid_q, out_valid_d;
  uart_pkg::rx_res_t          rx_res_q;
  uart_pkg::tx_res_t          tx_res_q;

  // Hold the bit period; the user must write it only while the block is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_ticks_q <= uart_pkg::BIT_TICKS_RST;
    end else if (cfg_we_i) begin
      bit_ticks_q <= cfg_wdata_i;
    end
  end

  // Accept a request whenever the result register is empty or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign adv        = in_valid_i && in_ready_o;

  uart_rx #(
    .DATA_BITS (DATA_BITS)
  ) u_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .rx_line_i   (rx_line_i),
    .bit_ticks_i (bit_ticks_q),
    .res_o       (rx_res)
  );

  uart_tx #(
    .DATA_BITS (DATA_BITS)
  ) u_tx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .send_valid_i (send_valid_i),
    .send_byte_i  (send_byte_i),
    .bit_ticks_i  (bit_ticks_q),
    .res_o        (tx_res)
  );

  // Result register: fill on accept, drop when the consumer takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rx_res_q <= rx_res;
      tx_res_q <= tx_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tx_line_o   = tx_res_q.line;
  assign tx_busy_o   = tx_res_q.busy;
  assign rx_valid_o  = rx_res_q.valid;
  assign rx_byte_o   = rx_res_q.data;

endmodule

// ===== sv/uart_rx.sv =====
// UART receiver: start detect, mid-bit sampling and byte report.
`timescale 1ns / 1ps

module uart_rx #(
  parameter int unsigned DATA_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        rx_line_i,
  input  logic [uart_pkg::CNT_W-1:0]  bit_ticks_i,
  output uart_pkg::rx_res_t           res_o
);

  localparam int unsigned IDX_W = $clog2(DATA_BITS + 1);

  uart_pkg::phase_e                  phase_q, phase_d;
  logic [uart_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [IDX_W-1:0]                  idx_q, idx_d;
  logic [uart_pkg::BYTE_W-1:0]       shift_q, shift_d;
  logic [IDX_W-1:0]                  idx_inc;

  assign idx_inc = idx_q + IDX_W'(1);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    shift_d = shift_q;
    res_o   = '0;
    if (phase_q == uart_pkg::PH_IDLE) begin
      if (!rx_line_i) begin
        phase_d = uart_pkg::PH_FIRST;
        cnt_d   = bit_ticks_i >> 1;
        idx_d   = '0;
        shift_d = '0;
      end
    end else if (cnt_q > uart_pkg::CNT_W'(1)) begin
      cnt_d = cnt_q - uart_pkg::CNT_W'(1);
    end else begin
      unique case (phase_q)
        uart_pkg::PH_FIRST: begin
          phase_d = uart_pkg::PH_SECOND;
          cnt_d   = bit_ticks_i;
        end
        uart_pkg::PH_SECOND: begin
          // keep only the bits that fit the byte
          if ({1'b0, idx_q} < (IDX_W + 1)'(uart_pkg::BYTE_W)) begin
            shift_d[idx_q[2:0]] = shift_q[idx_q[2:0]] | rx_line_i;
          end
          idx_d = idx_inc;
          cnt_d = bit_ticks_i;
          if (idx_inc >= IDX_W'(DATA_BITS)) begin
            phase_d = uart_pkg::PH_LAST;
          end
        end
        default: begin
          res_o.valid = 1'b1;
          res_o.data  = shift_q;
          phase_d     = uart_pkg::PH_IDLE;
          cnt_d       = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= uart_pkg::PH_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      shift_q <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
    end
  end

endmodule

// ===== sv/uart_tx.sv =====
// UART transmitter: idle bit, start bit and data bits, LSB first.
`timescale 1ns / 1ps

module uart_tx #(
  parameter int unsigned DATA_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        send_valid_i,
  input  logic [uart_pkg::BYTE_W-1:0] send_byte_i,
  input  logic [uart_pkg::CNT_W-1:0]  bit_ticks_i,
  output uart_pkg::tx_res_t           res_o
);

  localparam int unsigned IDX_W = $clog2(DATA_BITS + 1);

  uart_pkg::phase_e                  phase_q, phase_d;
  logic [uart_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [IDX_W-1:0]                  idx_q, idx_d;
  logic [uart_pkg::BYTE_W-1:0]       shift_q, shift_d;
  logic                              level_q, level_d;
  logic [IDX_W-1:0]                  idx_inc;

  assign idx_inc = idx_q + IDX_W'(1);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    shift_d = shift_q;
    level_d = level_q;
    if (phase_q != uart_pkg::PH_IDLE) begin
      if (cnt_q > uart_pkg::CNT_W'(1)) begin
        cnt_d = cnt_q - uart_pkg::CNT_W'(1);
      end else begin
        cnt_d = bit_ticks_i;
        unique case (phase_q)
          uart_pkg::PH_FIRST: begin
            phase_d = uart_pkg::PH_SECOND;
            level_d = 1'b0;
          end
          uart_pkg::PH_SECOND: begin
            phase_d = uart_pkg::PH_LAST;
            idx_d   = '0;
            level_d = shift_q[0];
          end
          default: begin
            idx_d = idx_inc;
            if (idx_inc >= IDX_W'(DATA_BITS)) begin
              phase_d = uart_pkg::PH_IDLE;
              cnt_d   = '0;
              level_d = 1'b1;
            end else if ({1'b0, idx_inc} < (IDX_W + 1)'(uart_pkg::BYTE_W)) begin
              level_d = shift_q[idx_inc[2:0]];
            end else begin
              level_d = 1'b0;
            end
          end
        endcase
      end
    end
    // take a request on any tick that ends idle, frame end included
    if (phase_d == uart_pkg::PH_IDLE && send_valid_i) begin
      phase_d = uart_pkg::PH_FIRST;
      cnt_d   = bit_ticks_i;
      idx_d   = '0;
      shift_d = send_byte_i;
      level_d = 1'b1;
    end
    res_o.line = level_d;
    res_o.busy = (phase_d != uart_pkg::PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= uart_pkg::PH_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      shift_q <= '0;
      level_q <= 1'b1;
    end else if (adv_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
      level_q <= level_d;
    end
  end

endmodule

// ===== tb/sv/uart_8n1_transceiver_unit_tb.sv =====
// Self-checking testbench for the UART 8N1 transceiver unit.
`timescale 1ns / 1ps

module uart_8n1_transceiver_unit_tb;

  localparam int unsigned DATA_BITS   = 8;
  localparam int unsigned NUM_PHASES  = 6;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned SEND_PCT    = 40;

  // Bit period and request count of each phase. Phase 0 is the directed
  // part; the last phase runs the longest bit period for a short while.
  localparam logic [uart_pkg::CNT_W-1:0] PHASE_TICKS [NUM_PHASES] =
    '{16'd2, 16'd2, 16'd3, 16'd8, 16'd5, 16'd65535};
  localparam int unsigned PHASE_LEN [NUM_PHASES] = '{24, 300, 300, 320, 300, 60};

  // One request: a tick with the sampled receive level and a send request.
  typedef struct packed {
    logic                        rx;
    logic                        req;
    logic [uart_pkg::BYTE_W-1:0] data;
  } tick_in_t;

  // One result: transmit state after the tick and the receive report.
  typedef struct packed {
    uart_pkg::tx_res_t tx;
    uart_pkg::rx_res_t rx;
  } tick_res_t;

  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        cfg_we_i     = 1'b0;
  logic [uart_pkg::CNT_W-1:0]  cfg_wdata_i  = '0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_ready_o;
  logic                        rx_line_i    = 1'b1;
  logic                        send_valid_i = 1'b0;
  logic [uart_pkg::BYTE_W-1:0] send_byte_i  = '0;
  logic                        out_valid_o;
  logic                        out_ready_i  = 1'b0;
  logic                        tx_line_o;
  logic                        tx_busy_o;
  logic                        rx_valid_o;
  logic [uart_pkg::BYTE_W-1:0] rx_byte_o;

  uart_8n1_transceiver_unit #(
    .DATA_BITS(DATA_BITS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_line_i   (rx_line_i),
    .send_valid_i(send_valid_i),
    .send_byte_i (send_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tx_line_o   (tx_line_o),
    .tx_busy_o   (tx_busy_o),
    .rx_valid_o  (rx_valid_o),
    .rx_byte_o   (rx_byte_o)
  );

  always #4 clk_i = ~clk_i;

  tick_in_t    tick_q [$];   // requests waiting to be driven
  tick_res_t   line_q [$];   // predicted results, oldest first
  tick_res_t   want;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned err_cnt      = 0;
  int unsigned stall_cnt    = 0;

  // Predictor copy of the bit period and of both framers.
  logic [uart_pkg::CNT_W-1:0]  bit_ticks = uart_pkg::BIT_TICKS_RST;
  uart_pkg::phase_e            rx_ph     = uart_pkg::PH_IDLE;
  logic [uart_pkg::CNT_W-1:0]  rx_cnt    = '0;
  logic [3:0]                  rx_idx    = '0;
  logic [uart_pkg::BYTE_W-1:0] rx_sr     = '0;
  uart_pkg::phase_e            tx_ph     = uart_pkg::PH_IDLE;
  logic [uart_pkg::CNT_W-1:0]  tx_cnt    = '0;
  logic [3:0]                  tx_idx    = '0;
  logic [uart_pkg::BYTE_W-1:0] tx_sr     = '0;
  logic                        tx_lvl    = 1'b1;

  // Advance both framers by one tick and return what the block should report.
  function automatic tick_res_t advance_tick(logic rx, logic req,
                                             logic [uart_pkg::BYTE_W-1:0] data);
    tick_res_t res;
    res = '0;

    // Receiver: start edge, half-bit offset, eight samples, then report.
    if (rx_ph == uart_pkg::PH_IDLE) begin
      if (!rx) begin
        rx_ph  = uart_pkg::PH_FIRST;
        rx_cnt = bit_ticks >> 1;
        rx_idx = '0;
        rx_sr  = '0;
      end
    end else if (rx_cnt > 1) begin
      rx_cnt--;
    end else if (rx_ph == uart_pkg::PH_FIRST) begin
      rx_ph  = uart_pkg::PH_SECOND;
      rx_cnt = bit_ticks;
    end else if (rx_ph == uart_pkg::PH_SECOND) begin
      // Keep only the low eight bits of a wider frame.
      if (rx_idx < 8 && rx) begin
        rx_sr[rx_idx[2:0]] = 1'b1;
      end
      rx_idx++;
      rx_cnt = bit_ticks;
      if (rx_idx >= DATA_BITS) begin
        rx_ph = uart_pkg::PH_LAST;
      end
    end else begin
      res.rx.valid = 1'b1;
      res.rx.data  = rx_sr;
      rx_ph        = uart_pkg::PH_IDLE;
      rx_cnt       = '0;
    end

    // Transmitter: idle bit, start bit, data bits, then line back high.
    if (tx_ph != uart_pkg::PH_IDLE) begin
      if (tx_cnt > 1) begin
        tx_cnt--;
      end else begin
        tx_cnt = bit_ticks;
        if (tx_ph == uart_pkg::PH_FIRST) begin
          tx_ph  = uart_pkg::PH_SECOND;
          tx_lvl = 1'b0;
        end else if (tx_ph == uart_pkg::PH_SECOND) begin
          tx_ph  = uart_pkg::PH_LAST;
          tx_idx = '0;
          tx_lvl = tx_sr[0];
        end else begin
          tx_idx++;
          if (tx_idx >= DATA_BITS) begin
            tx_ph  = uart_pkg::PH_IDLE;
            tx_cnt = '0;
            tx_lvl = 1'b1;
          end else begin
            tx_lvl = (tx_idx < 8) ? tx_sr[tx_idx[2:0]] : 1'b0;
          end
        end
      end
    end
    // A request lands on any tick the transmitter is idle, even the one
    // that just closed a frame; requests while busy are dropped.
    if (tx_ph == uart_pkg::PH_IDLE && req) begin
      tx_ph  = uart_pkg::PH_FIRST;
      tx_cnt = bit_ticks;
      tx_idx = '0;
      tx_sr  = data;
      tx_lvl = 1'b1;
    end

    res.tx.line = tx_lvl;
    res.tx.busy = (tx_ph != uart_pkg::PH_IDLE);
    return res;
  endfunction

  // Receive-line level at tick pos of a well-formed frame carrying b:
  // start bit, eight data bits LSB first, stop bit, each period ticks long.
  function automatic logic frame_level(logic [uart_pkg::BYTE_W-1:0] b, int unsigned pos,
                                       int unsigned period);
    int unsigned slot;
    slot = pos / period;
    if (slot == 0) begin
      return 1'b0;
    end
    if (slot <= 8) begin
      return b[slot-1];
    end
    return 1'b1;
  endfunction

  // Queue one tick with the given receive level and a random send request.
  function automatic void queue_tick(logic rx);
    tick_in_t t;
    t.rx   = rx;
    t.req  = ($urandom_range(99) < SEND_PCT);
    t.data = uart_pkg::BYTE_W'($urandom);
    tick_q.push_back(t);
  endfunction

  // Fill one random phase: mostly clean frames with random content and
  // idle gaps, some frames cut short, some raw line noise.
  task automatic fill_random(int unsigned target);
    int unsigned                 start, len, kind, i, period;
    logic [uart_pkg::BYTE_W-1:0] b;
    start  = tick_q.size();
    period = 32'(bit_ticks);
    while (tick_q.size() - start < target) begin
      kind = $urandom_range(99);
      if (kind < 85) begin
        // Bias some frames toward all-zero and all-one bytes.
        if ($urandom_range(9) == 0) begin
          b = $urandom_range(1) ? 8'hFF : 8'h00;
        end else begin
          b = uart_pkg::BYTE_W'($urandom);
        end
        len = (kind < 70) ? 10 * period : $urandom_range(10 * period - 1, 1);
        for (i = 0; i < len && tick_q.size() - start < target; i++) begin
          queue_tick(frame_level(b, i, period));
        end
        len = $urandom_range(2 * period);
        for (i = 0; i < len && tick_q.size() - start < target; i++) begin
          queue_tick(1'b1);
        end
      end else begin
        len = $urandom_range(3 * period, 1);
        for (i = 0; i < len && tick_q.size() - start < target; i++) begin
          queue_tick(1'($urandom_range(1)));
        end
      end
    end
  endtask

  // Hold until every queued request is taken and every result has come back.
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (tick_q.size() != 0 || in_valid_i || line_q.size() != 0);
  endtask

  // Driver: predict each accepted request, then present the next one or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      rx_line_i    <= 1'b1;
      send_valid_i <= 1'b0;
      send_byte_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        line_q.push_back(advance_tick(rx_line_i, send_valid_i, send_byte_i));
      end
      // Hold the payload while a request is still waiting for ready.
      if (!in_valid_i || in_ready_o) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid_i   <= 1'b1;
          rx_line_i    <= tick_q[0].rx;
          send_valid_i <= tick_q[0].req;
          send_byte_i  <= tick_q[0].data;
          void'(tick_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result side: stall at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Monitor: valid and ready only move at the rising edge, so checking them
  // at the falling edge sees exactly the handshake of the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (line_q.size() == 0) begin
        $error("result with no request outstanding");
        err_cnt++;
      end else begin
        want = line_q.pop_front();
        if (tx_line_o !== want.tx.line) begin
          $error("tx_line: expected %0b, got %0b", want.tx.line, tx_line_o);
          err_cnt++;
        end
        if (tx_busy_o !== want.tx.busy) begin
          $error("tx_busy: expected %0b, got %0b", want.tx.busy, tx_busy_o);
          err_cnt++;
        end
        if (rx_valid_o !== want.rx.valid) begin
          $error("rx_valid: expected %0b, got %0b", want.rx.valid, rx_valid_o);
          err_cnt++;
        end
        if (rx_byte_o !== want.rx.data) begin
          $error("rx_byte: expected 0x%02h, got 0x%02h", want.rx.data, rx_byte_o);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: drop the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("FAIL uart_8n1_transceiver_unit");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Sequencer: reset once, then per phase set the bit period while the
  // block is drained, pick the idle mix and queue the requests.
  initial begin
    int unsigned ph, i;
    tick_in_t    t;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= PHASE_TICKS[ph];
      bit_ticks    = PHASE_TICKS[ph];
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      #1;
      // Sender mostly busy first, then the receiver, then no idling at all.
      unique case (ph / 2)
        0: begin
          src_idle_pct = 20;
          snk_idle_pct = 79;
        end
        1: begin
          src_idle_pct = 79;
          snk_idle_pct = 20;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      if (ph == 0) begin
        // Receive an all-zero frame while holding a send request of 0xFF
        // the whole time: the first request starts a frame, the rest are
        // dropped while busy, and the tick that closes the frame takes a
        // fresh request of 0x00.
        for (i = 0; i < PHASE_LEN[0]; i++) begin
          t.rx   = (i < 20) ? frame_level(8'h00, i, 32'(PHASE_TICKS[0])) : 1'b1;
          t.req  = 1'b1;
          t.data = (i < 20) ? 8'hFF : 8'h00;
          tick_q.push_back(t);
        end
      end else begin
        fill_random(PHASE_LEN[ph]);
      end
    end
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS uart_8n1_transceiver_unit");
    end else begin
      $display("FAIL uart_8n1_transceiver_unit");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/uart_pkg.sv
sv/uart_rx.sv
sv/uart_tx.sv
sv/uart_8n1_transceiver_unit.sv
tb/sv/uart_8n1_transceiver_unit_tb.sv
